// ----- design/tdf_pkg.sv -----
// Package for the timer divider factorizer: widths, constants, FSM state
// types and the request/response structs shared by the core's modules.
// No dependencies.
`timescale 1ns / 1ps

package tdf_pkg;

  // Counter width of the prescaler and reload registers
  localparam int CNT_W         = 16;
  localparam int COUNTER_RANGE = 1 << CNT_W;
  // Candidate prescaler / reload values run up to COUNTER_RANGE itself
  localparam int CAND_W        = CNT_W + 1;
  // Field widths
  localparam int RATIO_W       = 35;
  localparam int PROD_W        = 33;
  localparam int SCAN_W        = 32;
  // Serial divider: numerator width and step count
  localparam int NUM_W         = 33;
  localparam int DIV_STEPS     = NUM_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
  // Error magnitude |rem - x/2| fits in CAND_W bits
  localparam int ERR_W         = CAND_W;

  typedef enum logic [1:0] {
    TP_IDLE,
    TP_SCAN,
    TP_HOLD
  } tdf_top_state_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_ISSUE,
    SC_WAIT
  } tdf_scan_state_e;

  // Pre-divider codes
  localparam logic [1:0] PRE_DIV_1 = 2'd0;
  localparam logic [1:0] PRE_DIV_2 = 2'd1;
  localparam logic [1:0] PRE_DIV_4 = 2'd2;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  numer;
    logic [CAND_W-1:0] denom;
  } tdf_div_req_t;

  typedef struct packed {
    logic              done;
    logic [CAND_W-1:0] quot;
    logic [CAND_W-1:0] rem;
  } tdf_div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [SCAN_W-1:0] prod;
  } tdf_scan_req_t;

  typedef struct packed {
    logic              done;
    logic [CAND_W-1:0] prescale;
    logic [CAND_W-1:0] reload;
  } tdf_scan_rsp_t;

endpackage

// ----- design/tdf_in_if.sv -----
// Input channel of the timer divider factorizer: valid/ready plus ratio.
// Depends on tdf_pkg.
`timescale 1ns / 1ps

interface tdf_in_if;
  logic                        valid;
  logic                        ready;
  logic [tdf_pkg::RATIO_W-1:0] ratio;

  modport source (output valid, output ratio, input ready);
  modport sink   (input valid, input ratio, output ready);
endinterface

// ----- design/tdf_out_if.sv -----
// Output channel of the timer divider factorizer: valid/ready plus result.
// Depends on tdf_pkg.
`timescale 1ns / 1ps

interface tdf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      applied;
  logic [1:0]                pre_divider_code;
  logic [tdf_pkg::CNT_W-1:0] prescale_minus_one;
  logic [tdf_pkg::CNT_W-1:0] reload_minus_one;

  modport source (output valid, output applied, output pre_divider_code,
                  output prescale_minus_one, output reload_minus_one,
                  input ready);
  modport sink   (input valid, input applied, input pre_divider_code,
                  input prescale_minus_one, input reload_minus_one,
                  output ready);
endinterface

// ----- design/tdf_serial_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tdf_pkg.
`timescale 1ns / 1ps

module tdf_serial_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tdf_pkg::tdf_div_req_t req_i,
  output tdf_pkg::tdf_div_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [tdf_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [tdf_pkg::NUM_W-1:0]       num_q, num_d;
  logic [tdf_pkg::CAND_W-1:0]      den_q, den_d;
  logic [tdf_pkg::CAND_W-1:0]      rem_q, rem_d;
  logic [tdf_pkg::CAND_W-1:0]      quot_q, quot_d;
  logic [tdf_pkg::CAND_W:0]        trial;
  logic                            fits;

  // One restoring step: shift in the next numerator bit, try to subtract
  assign trial = {rem_q, num_q[tdf_pkg::NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = tdf_pkg::DIV_CNT_W'(tdf_pkg::DIV_STEPS);
      num_d  = req_i.numer;
      den_d  = req_i.denom;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      num_d  = {num_q[tdf_pkg::NUM_W-2:0], 1'b0};
      rem_d  = fits ? tdf_pkg::CAND_W'(trial - {1'b0, den_q})
                    : tdf_pkg::CAND_W'(trial);
      // quotient never exceeds CAND_W bits, so upper bits drop out as zero
      quot_d = {quot_q[tdf_pkg::CAND_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == tdf_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- design/tdf_scan.sv -----
// Prescaler search: steps candidates upward, divides each on the serial
// divider and keeps the first one with the smallest rounding error.
// Depends on tdf_pkg and tdf_serial_div.
`timescale 1ns / 1ps

module tdf_scan (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tdf_pkg::tdf_scan_req_t req_i,
  output tdf_pkg::tdf_scan_rsp_t rsp_o
);

  tdf_pkg::tdf_scan_state_e   state_q, state_d;
  logic [tdf_pkg::SCAN_W-1:0] prod_q, prod_d;
  logic [tdf_pkg::CAND_W-1:0] x_q, x_d;
  logic [tdf_pkg::CAND_W-1:0] best_x_q, best_x_d;
  logic [tdf_pkg::CAND_W-1:0] best_y_q, best_y_d;
  logic [tdf_pkg::ERR_W-1:0]  best_err_q, best_err_d;
  logic                       done_q, done_d;

  tdf_pkg::tdf_div_req_t      div_req;
  tdf_pkg::tdf_div_rsp_t      div_rsp;

  logic [tdf_pkg::CAND_W-1:0] x_first;
  logic [tdf_pkg::CAND_W:0]   err_diff;
  logic [tdf_pkg::ERR_W-1:0]  err_abs;

  tdf_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // First candidate: ceil(prod / COUNTER_RANGE)
  assign x_first = {1'b0, req_i.prod[tdf_pkg::SCAN_W-1:tdf_pkg::CNT_W]}
                 + tdf_pkg::CAND_W'(req_i.prod[tdf_pkg::CNT_W-1:0] != '0);

  // x*y - prod = floor(x/2) - rem, so the error needs no multiply
  assign err_diff = {1'b0, div_rsp.rem} - {2'b0, x_q[tdf_pkg::CAND_W-1:1]};
  assign err_abs  = err_diff[tdf_pkg::CAND_W] ? tdf_pkg::ERR_W'(-err_diff)
                                              : tdf_pkg::ERR_W'(err_diff);

  always_comb begin
    state_d       = state_q;
    prod_d        = prod_q;
    x_d           = x_q;
    best_x_d      = best_x_q;
    best_y_d      = best_y_q;
    best_err_d    = best_err_q;
    done_d        = 1'b0;
    div_req.start = 1'b0;
    div_req.numer = {1'b0, prod_q} + tdf_pkg::NUM_W'(x_q[tdf_pkg::CAND_W-1:1]);
    div_req.denom = x_q;
    unique case (state_q)
      tdf_pkg::SC_IDLE: begin
        if (req_i.start) begin
          prod_d     = req_i.prod;
          x_d        = x_first;
          best_x_d   = x_first;
          best_err_d = '1;
          state_d    = tdf_pkg::SC_ISSUE;
        end
      end
      tdf_pkg::SC_ISSUE: begin
        div_req.start = 1'b1;
        state_d       = tdf_pkg::SC_WAIT;
      end
      tdf_pkg::SC_WAIT: begin
        if (div_rsp.done) begin
          if (err_abs < best_err_q) begin
            best_err_d = err_abs;
            best_x_d   = x_q;
            best_y_d   = div_rsp.quot;
          end
          // stop at an exact fit or after the last candidate
          if (err_abs == '0 || x_q == tdf_pkg::CAND_W'(tdf_pkg::COUNTER_RANGE)) begin
            done_d  = 1'b1;
            state_d = tdf_pkg::SC_IDLE;
          end else begin
            x_d     = x_q + 1'b1;
            state_d = tdf_pkg::SC_ISSUE;
          end
        end
      end
      default: state_d = tdf_pkg::SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdf_pkg::SC_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    x_q        <= x_d;
    best_x_q   <= best_x_d;
    best_y_q   <= best_y_d;
    best_err_q <= best_err_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.prescale = best_x_q;
  assign rsp_o.reload   = best_y_q;

endmodule

// ----- design/timer_divider_factorizer_core.sv -----
// Top level of the timer divider factorizer: input classification,
// result register and output channel around the prescaler search.
// Depends on tdf_pkg, tdf_in_if, tdf_out_if and tdf_scan.
`timescale 1ns / 1ps

// Usage:
//   in_i  (sink):   one item carries a 35-bit total division ratio.
//   out_o (source): one result item per input item: applied flag,
//                   pre-divider code, prescaler-1 and reload-1.
//   Both channels move an item when valid and ready are high at a clock edge.
// Flow:
//   Rejected ratios, full products (2^32) and products up to 65536 skip the
//   search and go straight to the hold state, which loads out_o once it is free.
//   Otherwise the search tries N = 65537 - ceil(p/65536) candidates at most,
//   fewer when an exact fit turns up; each candidate is issued to the
//   bit-serial divider, which runs 33 steps, and its result is then checked.
// Throughput: one item at a time; in_i.ready is high only while idle.
//   A finished result sits in the output register, so the next item may be
//   accepted and searched while the receiver stalls; that item's result then
//   waits until the output register frees up.
// Reset: rst_ni is asynchronous, active low; clears the FSMs and out_o.valid.

module timer_divider_factorizer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdf_in_if.sink    in_i,
  tdf_out_if.source out_o
);

  localparam logic [tdf_pkg::RATIO_W-1:0] One32 = tdf_pkg::RATIO_W'(1) << 32;
  localparam logic [tdf_pkg::RATIO_W-1:0] Two32 = tdf_pkg::RATIO_W'(2) << 32;
  localparam logic [tdf_pkg::RATIO_W-1:0] Four32 = tdf_pkg::RATIO_W'(4) << 32;
  localparam logic [tdf_pkg::PROD_W-1:0]  FullProd = tdf_pkg::PROD_W'(1) << 32;
  localparam logic [tdf_pkg::PROD_W-1:0]  RangeProd =
    tdf_pkg::PROD_W'(tdf_pkg::COUNTER_RANGE);

  tdf_pkg::tdf_top_state_e   state_q, state_d;
  logic                      res_applied_q, res_applied_d;
  logic [1:0]                res_code_q, res_code_d;
  logic [tdf_pkg::CNT_W-1:0] res_psc_q, res_psc_d;
  logic [tdf_pkg::CNT_W-1:0] res_rld_q, res_rld_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_applied_q;
  logic [1:0]                out_code_q;
  logic [tdf_pkg::CNT_W-1:0] out_psc_q;
  logic [tdf_pkg::CNT_W-1:0] out_rld_q;
  logic                      out_load;

  logic                        reject;
  logic [1:0]                  code;
  logic [tdf_pkg::PROD_W-1:0]  prod;

  tdf_pkg::tdf_scan_req_t scan_req;
  tdf_pkg::tdf_scan_rsp_t scan_rsp;

  tdf_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scan_req),
    .rsp_o  (scan_rsp)
  );

  // Classify the ratio and pre-divide large ones
  always_comb begin
    reject = (in_i.ratio == '0) || (in_i.ratio > Four32);
    if (in_i.ratio > Two32) begin
      code = tdf_pkg::PRE_DIV_4;
      prod = tdf_pkg::PROD_W'(in_i.ratio >> 2);
    end else if (in_i.ratio > One32) begin
      code = tdf_pkg::PRE_DIV_2;
      prod = tdf_pkg::PROD_W'(in_i.ratio >> 1);
    end else begin
      code = tdf_pkg::PRE_DIV_1;
      prod = tdf_pkg::PROD_W'(in_i.ratio);
    end
  end

  // Control FSM
  always_comb begin
    state_d        = state_q;
    res_applied_d  = res_applied_q;
    res_code_d     = res_code_q;
    res_psc_d      = res_psc_q;
    res_rld_d      = res_rld_q;
    out_load       = 1'b0;
    in_i.ready     = 1'b0;
    scan_req.start = 1'b0;
    scan_req.prod  = prod[tdf_pkg::SCAN_W-1:0];
    unique case (state_q)
      tdf_pkg::TP_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          res_code_d = code;
          priority if (reject) begin
            res_applied_d = 1'b0;
            res_code_d    = tdf_pkg::PRE_DIV_1;
            res_psc_d     = '0;
            res_rld_d     = '0;
            state_d       = tdf_pkg::TP_HOLD;
          end else if (prod >= FullProd) begin
            res_applied_d = 1'b1;
            res_psc_d     = '1;
            res_rld_d     = '1;
            state_d       = tdf_pkg::TP_HOLD;
          end else if (prod <= RangeProd) begin
            res_applied_d = 1'b1;
            res_psc_d     = '0;
            res_rld_d     = prod[tdf_pkg::CNT_W-1:0] - 1'b1;
            state_d       = tdf_pkg::TP_HOLD;
          end else begin
            res_applied_d  = 1'b1;
            scan_req.start = 1'b1;
            state_d        = tdf_pkg::TP_SCAN;
          end
        end
      end
      tdf_pkg::TP_SCAN: begin
        if (scan_rsp.done) begin
          res_psc_d = tdf_pkg::CNT_W'(scan_rsp.prescale - 1'b1);
          res_rld_d = tdf_pkg::CNT_W'(scan_rsp.reload - 1'b1);
          state_d   = tdf_pkg::TP_HOLD;
        end
      end
      tdf_pkg::TP_HOLD: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = tdf_pkg::TP_IDLE;
        end
      end
      default: state_d = tdf_pkg::TP_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdf_pkg::TP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_applied_q <= res_applied_d;
    res_code_q    <= res_code_d;
    res_psc_q     <= res_psc_d;
    res_rld_q     <= res_rld_d;
    if (out_load) begin
      out_applied_q <= res_applied_q;
      out_code_q    <= res_code_q;
      out_psc_q     <= res_psc_q;
      out_rld_q     <= res_rld_q;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.applied            = out_applied_q;
  assign out_o.pre_divider_code   = out_code_q;
  assign out_o.prescale_minus_one = out_psc_q;
  assign out_o.reload_minus_one   = out_rld_q;

endmodule

// ----- dv/tb.sv -----
// Testbench for timer_divider_factorizer_core: drives ratios through the input
// channel and checks each result against a built-in prescaler/reload search.
// Depends on tdf_pkg, tdf_in_if, tdf_out_if and the core RTL.
`timescale 1ns / 1ps

module tb;
  import tdf_pkg::*;

  localparam longint unsigned ONE32        = 64'd1 << 32;
  localparam int              LIMIT_CYCLES = 2000000;
  localparam int              HOLD_CYCLES  = 6000;
  localparam int              PHASE_ITEMS  = 26;

  // Expected result of one ratio
  typedef struct packed {
    logic             applied;
    logic [1:0]       code;
    logic [CNT_W-1:0] psc_m1;
    logic [CNT_W-1:0] rld_m1;
  } timer_split_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    timer_split_t       split;
  } pending_split_t;

  logic clk_i;
  logic rst_ni;

  tdf_in_if  in_if ();
  tdf_out_if out_if ();

  timer_divider_factorizer_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [RATIO_W-1:0] ratio_queue[$];
  pending_split_t     expected_splits[$];

  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_start;
  int  hold_left;
  bit  in_taken;
  int  errors;
  int  cycle_count;
  int  n_checked;
  int  n_rejected;
  int  n_code[3];
  int  n_in_stall;

  // Search for prescaler and reload, first best fit wins
  function automatic timer_split_t split_ratio(input logic [RATIO_W-1:0] ratio);
    longint unsigned rng, prod, best_x, best_err, x, y, xy, err;
    timer_split_t    res;
    res = '0;
    rng = COUNTER_RANGE;
    if (ratio == 0 || ratio > 4 * ONE32) begin
      return res;
    end
    if (ratio > 2 * ONE32) begin
      res.code = PRE_DIV_4;
      prod     = ratio >> 2;
    end else if (ratio > ONE32) begin
      res.code = PRE_DIV_2;
      prod     = ratio >> 1;
    end else begin
      res.code = PRE_DIV_1;
      prod     = ratio;
    end
    if (prod >= rng * rng) begin
      best_x = rng;
      y      = rng;
    end else if (prod <= rng) begin
      best_x = 1;
      y      = prod;
    end else begin
      best_x   = (prod + rng - 1) / rng;
      best_err = 64'hFFFF_FFFF_FFFF_FFFF;
      for (x = best_x; x <= rng; x++) begin
        y   = (prod + x / 2) / x;
        xy  = x * y;
        err = (xy > prod) ? xy - prod : prod - xy;
        if (err < best_err) begin
          best_err = err;
          best_x   = x;
          if (err == 0) break;
        end
      end
      y = (prod + best_x / 2) / best_x;
    end
    res.applied = 1'b1;
    res.psc_m1  = CNT_W'(best_x - 1);
    res.rld_m1  = CNT_W'(y - 1);
    return res;
  endfunction

  // Wrap a product into a ratio with a random legal pre-divider
  function automatic logic [RATIO_W-1:0] ratio_for_product(input longint unsigned prod);
    int              code;
    longint unsigned low;
    code = (prod < (ONE32 >> 1)) ? 0 : $urandom_range(2, 0);
    if (code == 0) begin
      return RATIO_W'(prod);
    end
    low = (code == 1) ? $urandom_range(1, 0) : $urandom_range(3, 0);
    if (prod == ONE32) low = 0;
    if (prod == (ONE32 >> 1) && low == 0) low = 1;
    return (code == 1) ? RATIO_W'(2 * prod + low) : RATIO_W'(4 * prod + low);
  endfunction

  // Random ratio; searched products are kept to short scans
  function automatic logic [RATIO_W-1:0] random_ratio();
    int              pick;
    longint unsigned x, y;
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      // exact fit close to the first candidate
      x = $urandom_range(COUNTER_RANGE, 2);
      y = COUNTER_RANGE - $urandom_range(63, 0);
      return ratio_for_product(x * y);
    end else if (pick < 55) begin
      // start of scan near the top, inexact fits likely
      x = 64'd65500 * COUNTER_RANGE + 1 + $urandom_range(36 * COUNTER_RANGE - 2, 0);
      return ratio_for_product(x);
    end else if (pick < 70) begin
      return RATIO_W'($urandom_range(COUNTER_RANGE, 1));
    end else if (pick < 90) begin
      if ($urandom_range(9, 0) == 0) return '0;
      return {1'b1, 2'($urandom), 32'($urandom)};
    end else begin
      case ($urandom_range(2, 0))
        0:       return RATIO_W'(ONE32);
        1:       return RATIO_W'(2 * ONE32);
        default: return RATIO_W'(4 * ONE32);
      endcase
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [RATIO_W-1:0] ratio,
                                 input longint unsigned got, input longint unsigned want);
    $display("MISMATCH %s for ratio %0d: got %0d, expected %0d", what, ratio, got, want);
    errors++;
  endtask

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Sender: next ratio once the current item has gone
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (ratio_queue.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.ratio <= ratio_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // Monitor: predict on input, check on output
  always @(posedge clk_i) begin
    pending_split_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && !in_if.ready) n_in_stall++;
      if (in_if.valid && in_if.ready) begin
        want.ratio = in_if.ratio;
        want.split = split_ratio(in_if.ratio);
        expected_splits.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_splits.size() == 0) begin
          report_mismatch("unexpected result", '0, out_if.applied, 0);
        end else begin
          want = expected_splits.pop_front();
          n_checked++;
          if (!want.split.applied) n_rejected++;
          else if (want.split.code <= PRE_DIV_4) n_code[want.split.code]++;
          if (out_if.applied !== want.split.applied)
            report_mismatch("applied", want.ratio, out_if.applied, want.split.applied);
          if (out_if.pre_divider_code !== want.split.code)
            report_mismatch("pre_divider_code", want.ratio, out_if.pre_divider_code,
                            want.split.code);
          if (out_if.prescale_minus_one !== want.split.psc_m1)
            report_mismatch("prescale_minus_one", want.ratio, out_if.prescale_minus_one,
                            want.split.psc_m1);
          if (out_if.reload_minus_one !== want.split.rld_m1)
            report_mismatch("reload_minus_one", want.ratio, out_if.reload_minus_one,
                            want.split.rld_m1);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_splits.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    longint unsigned directed[];
    directed = '{
      0, 1, 2, 3, 65535, 65536, 65538, 131072,
      64'd4294901760, 64'd4294901761, 64'd4294967295, 64'd4294967296,
      64'd4294967297, 64'd5240000001, 64'd8589934592, 64'd8589934593,
      64'd8589934595, 64'd17179869183, 64'd17179869184, 64'd17179869185,
      64'd34359738367
    };
    in_if.valid  = 1'b0;
    in_if.ratio  = '0;
    out_if.ready = 1'b0;
    hold_start   = 1'b0;
    hold_left    = 0;
    errors       = 0;
    tx_idle_pct  = 9;
    rx_idle_pct  = 67;
    rst_ni       = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase 0: directed corners, then random; sender busy, receiver slow
    foreach (directed[i]) ratio_queue.push_back(RATIO_W'(directed[i]));
    repeat (PHASE_ITEMS) ratio_queue.push_back(random_ratio());
    while (ratio_queue.size() != 0) @(posedge clk_i);

    // Phase 1: sender slow, receiver busy
    tx_idle_pct = 67;
    rx_idle_pct = 9;
    repeat (PHASE_ITEMS) ratio_queue.push_back(random_ratio());
    while (ratio_queue.size() != 0) @(posedge clk_i);

    // Phase 2: no idling; receiver holds off so the core backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_start  = 1'b1;
    repeat (PHASE_ITEMS) ratio_queue.push_back(random_ratio());
    while (ratio_queue.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_splits.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (expected_splits.size() != 0)
      report_mismatch("missing results", '0, 0, expected_splits.size());
    $display("Checked %0d results: %0d rejected, %0d by 1, %0d by 2, %0d by 4",
             n_checked, n_rejected, n_code[0], n_code[1], n_code[2]);
    $display("Input back-pressure seen on %0d cycles, %0d mismatches", n_in_stall, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
